// ===== design/srf_pkg.sv =====
// Shared types and constants for the serial record FIFO.
// Holds record/queue sizing, status codes and the controller/datapath link structs.
// No dependencies.
package srf_pkg;

    // Sizing
    localparam int RECORD_BYTES = 8;
    localparam int QUEUE_DEPTH  = 8;

    // Field widths fixed by the interface
    localparam int BYTE_DATA_W = 8;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 4;

    // Ring has one spare slot so the slot being assembled never holds a queued record
    localparam int RING_SLOTS  = QUEUE_DEPTH + 1;
    localparam int SLOT_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int IDX_W       = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int STORE_DEPTH = RING_SLOTS * RECORD_BYTES;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BYTE    = 3'd4
    } status_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic issue_read;  // read next record byte from the store
        logic load_byte;   // move read data into the output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic queue_empty; // no records held
        logic last_byte;   // byte being streamed is the final one of its record
        logic out_free;    // output register empty or being taken this cycle
    } sts_t;

endpackage

// ===== design/srf_ctrl.sv =====
// Controller for the serial record FIFO: input handshake and record streaming sequence.
// Depends on srf_pkg.
module srf_ctrl
    import srf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic op,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input is taken only when idle and the output register can take a result
    always_comb
    begin
        in_stall = !((state_reg == S_IDLE) && sts.out_free);
        accept   = in_valid && !in_stall;
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = accept;
        cmd.issue_read = (state_reg == S_READ);
        cmd.load_byte  = (state_reg == S_LOAD) && sts.out_free;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op && !sts.queue_empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_byte ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/srf_datapath.sv =====
// Datapath for the serial record FIFO: record store, ring pointers, fill and
// stream counters, and the output register. Depends on srf_pkg.
module srf_datapath
    import srf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   op,
    input  logic [BYTE_DATA_W-1:0] rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BYTE_DATA_W-1:0] out_byte,
    output logic                   last,
    output logic [STATUS_W-1:0]    status,
    output logic [OCC_W-1:0]       occupancy
);

    // Record store; slot s holds bytes s*RECORD_BYTES .. s*RECORD_BYTES+RECORD_BYTES-1
    logic [BYTE_DATA_W-1:0] store_mem [STORE_DEPTH];

    // Control registers
    logic [IDX_W-1:0]  fill_reg,     fill_next;
    logic [SLOT_W-1:0] head_reg,     head_next;
    logic [SLOT_W-1:0] tail_reg,     tail_next;
    logic [OCC_W-1:0]  count_reg,    count_next;
    logic [SLOT_W-1:0] rd_slot_reg,  rd_slot_next;
    logic [IDX_W-1:0]  byte_idx_reg, byte_idx_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [BYTE_DATA_W-1:0] rd_data_reg;
    logic [BYTE_DATA_W-1:0] out_byte_reg;
    logic                   last_reg;
    status_t                status_reg;
    logic [OCC_W-1:0]       occ_reg;

    // Single-result capture
    logic                   res_valid;
    status_t                res_status;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   fill_done;
    logic                   queue_full;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(RING_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // Status to controller
    always_comb
    begin
        sts.queue_empty = (count_reg == '0);
        sts.last_byte   = (byte_idx_reg == IDX_W'(RECORD_BYTES - 1));
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // Addresses
    always_comb
    begin
        wr_addr = ADDR_W'(tail_reg) * ADDR_W'(RECORD_BYTES) + ADDR_W'(fill_reg);
        rd_addr = ADDR_W'(rd_slot_reg) * ADDR_W'(RECORD_BYTES) + ADDR_W'(byte_idx_reg);
    end

    // Pointer and counter updates
    always_comb
    begin
        fill_next     = fill_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        rd_slot_next  = rd_slot_reg;
        byte_idx_next = byte_idx_reg;
        res_valid     = 1'b0;
        res_status    = ST_STORED;
        wr_en         = 1'b0;
        fill_done     = (fill_reg == IDX_W'(RECORD_BYTES - 1));
        queue_full    = (count_reg == OCC_W'(QUEUE_DEPTH));

        if (cmd.accept)
        begin
            if (!op)
            begin
                // Byte lands directly in the tail slot being assembled
                wr_en     = 1'b1;
                res_valid = 1'b1;
                if (fill_done)
                begin
                    fill_next = '0;
                    if (queue_full)
                    begin
                        res_status = ST_DROPPED;
                    end
                    else
                    begin
                        tail_next  = slot_inc(tail_reg);
                        count_next = count_reg + OCC_W'(1);
                        res_status = ST_QUEUED;
                    end
                end
                else
                begin
                    fill_next = fill_reg + IDX_W'(1);
                end
            end
            else if (count_reg == '0)
            begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
            end
            else
            begin
                // Pop the head record; bytes stream out of rd_slot afterwards
                rd_slot_next  = head_reg;
                head_next     = slot_inc(head_reg);
                count_next    = count_reg - OCC_W'(1);
                byte_idx_next = '0;
            end
        end

        if (cmd.load_byte)
        begin
            byte_idx_next = sts.last_byte ? '0 : byte_idx_reg + IDX_W'(1);
        end

        // Output register valid
        if (res_valid || cmd.load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_slot_reg   <= '0;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_slot_reg   <= rd_slot_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Record store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= rx_byte;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_byte_reg <= '0;
            last_reg     <= 1'b1;
            status_reg   <= res_status;
            occ_reg      <= count_next;
        end
        else if (cmd.load_byte)
        begin
            out_byte_reg <= rd_data_reg;
            last_reg     <= sts.last_byte;
            status_reg   <= ST_BYTE;
            occ_reg      <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

// ===== design/serial_record_fifo.sv =====
// Serial record FIFO top level: controller plus datapath.
// Depends on srf_pkg, srf_ctrl, srf_datapath.
//
// Input channel (in_valid/in_stall, op, rx_byte): op 0 hands in a received
// byte, op 1 asks for the oldest queued record. Output channel
// (out_valid/out_stall, out_byte, last, status, occupancy) returns results.
// A byte, or a dequeue on an empty queue, gives one result, registered in the
// cycle after the transfer; the input can take a new item every cycle while
// the output is drained.
// A dequeue of a record streams RECORD_BYTES results, each made by a registered
// store read and then an output register load; input is stalled until the last
// byte is loaded. Records are assembled in place in a spare ring slot, so a
// completed record is queued with no copy.
// Reset clears the queue, the partial record and the output register; no
// clearing pass is needed. When out_stall is high a held result stays in the
// output register and the input is stalled until it frees.
module serial_record_fifo
    import srf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [BYTE_DATA_W-1:0] rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BYTE_DATA_W-1:0] out_byte,
    output logic                   last,
    output logic [STATUS_W-1:0]    status,
    output logic [OCC_W-1:0]       occupancy
);

    cmd_t cmd;
    sts_t sts;

    srf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    srf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule

// ===== bench/srf_checker.sv =====
`timescale 1ns / 100ps
// Checker for serial_record_fifo: watches both channels, predicts results and compares them.
// Depends on srf_pkg for sizing and status codes.
module srf_checker
    import srf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   op,
    input  logic [BYTE_DATA_W-1:0] rx_byte,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [BYTE_DATA_W-1:0] out_byte,
    input  logic                   last,
    input  logic [STATUS_W-1:0]    status,
    input  logic [OCC_W-1:0]       occupancy,
    output int                     fail_count,
    output int                     results_owed,
    output int                     results_checked,
    output int                     drops_seen,
    output int                     empties_seen
);

    typedef struct {
        logic [BYTE_DATA_W-1:0] data;
        logic                   last_flag;
        status_t                st;
        logic [OCC_W-1:0]       occ;
    } srf_result_t;

    // Shadow copy of the queue state
    logic [BYTE_DATA_W-1:0] partial_rec [RECORD_BYTES];
    logic [BYTE_DATA_W-1:0] rec_ring    [QUEUE_DEPTH][RECORD_BYTES];
    int                     partial_fill;
    int                     ring_head;
    int                     ring_tail;
    int                     records_held;

    srf_result_t            results_due[$];

    // Apply one input transfer to the shadow queue and queue up its results
    function automatic void apply_serial_op(input logic op_v, input logic [BYTE_DATA_W-1:0] data_v);
        srf_result_t r;
        int          slot;
        r.data      = '0;
        r.last_flag = 1'b1;
        r.st        = ST_STORED;
        if (op_v == 1'b0)
        begin
            partial_rec[partial_fill] = data_v;
            partial_fill++;
            if (partial_fill >= RECORD_BYTES)
            begin
                if (records_held >= QUEUE_DEPTH)
                begin
                    r.st = ST_DROPPED;
                    drops_seen++;
                end
                else
                begin
                    for (int i = 0; i < RECORD_BYTES; i++)
                        rec_ring[ring_tail][i] = partial_rec[i];
                    ring_tail    = (ring_tail + 1) % QUEUE_DEPTH;
                    records_held++;
                    r.st = ST_QUEUED;
                end
                partial_fill = 0;
            end
            r.occ = OCC_W'(records_held);
            results_due.push_back(r);
        end
        else if (records_held == 0)
        begin
            r.st  = ST_EMPTY;
            r.occ = '0;
            empties_seen++;
            results_due.push_back(r);
        end
        else
        begin
            slot      = ring_head;
            ring_head = (ring_head + 1) % QUEUE_DEPTH;
            records_held--;
            for (int i = 0; i < RECORD_BYTES; i++)
            begin
                r.data      = rec_ring[slot][i];
                r.last_flag = (i == RECORD_BYTES - 1);
                r.st        = ST_BYTE;
                r.occ       = OCC_W'(records_held);
                results_due.push_back(r);
            end
        end
    endfunction

    // Compare each output transfer with the oldest prediction, then predict the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        srf_result_t want;
        if (!rst_n)
        begin
            partial_fill    = 0;
            ring_head       = 0;
            ring_tail       = 0;
            records_held    = 0;
            fail_count      = 0;
            results_checked = 0;
            drops_seen      = 0;
            empties_seen    = 0;
            results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h last %0b status %0d occupancy %0d",
                           out_byte, last, status, occupancy);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        fail_count++;
                    end
                    if (last !== want.last_flag)
                    begin
                        $error("last: expected %0b, got %0b", want.last_flag, last);
                        fail_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        fail_count++;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_serial_op(op, rx_byte);
        end
        results_owed = results_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the serial_record_fifo bench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on srf_pkg, serial_record_fifo and srf_checker.
module testbench;
    import srf_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * RECORD_BYTES + 8;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 299;
    localparam int HOLD_AT      = 60;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [BYTE_DATA_W-1:0] rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [BYTE_DATA_W-1:0] out_byte;
    logic                   last;
    logic [STATUS_W-1:0]    status;
    logic [OCC_W-1:0]       occupancy;

    int fail_count;
    int results_owed;
    int results_checked;
    int drops_seen;
    int empties_seen;

    int   items_sent;
    bit   calm;
    bit   hold_request;
    int   hold_left;
    int   quiet_cycles;

    serial_record_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status),
        .occupancy (occupancy)
    );

    srf_checker srf_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last            (last),
        .status          (status),
        .occupancy       (occupancy),
        .fail_count      (fail_count),
        .results_owed    (results_owed),
        .results_checked (results_checked),
        .drops_seen      (drops_seen),
        .empties_seen    (empties_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one item, sometimes after an idle gap, and hold it until the transfer
    task automatic send_item(input logic op_v, input logic [BYTE_DATA_W-1:0] data_v);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 14)
            gap = 1;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            op       <= 1'($urandom_range(1));
            rx_byte  <= BYTE_DATA_W'($urandom_range(255));
        end
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= op_v;
        rx_byte  <= data_v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the calm stretch
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall    <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 14);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int seg_pct[6];
        int seg_len[6];
        int seg;
        int seg_pos;
        logic [BYTE_DATA_W-1:0] edge_bytes[8];

        seg_pct    = '{0, 20, 85, 10, 50, 2};
        seg_len    = '{80, 60, 25, 70, 60, 90};
        edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'hFE};

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = 1'b0;
        rx_byte      = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty dequeue, one full record of edge values, partial record cases
        send_item(OP_DEQUEUE, BYTE_DATA_W'($urandom_range(255)));
        for (int i = 0; i < RECORD_BYTES; i++)
            send_item(OP_RX_BYTE, edge_bytes[i % 8]);
        send_item(OP_DEQUEUE, BYTE_DATA_W'($urandom_range(255)));
        send_item(OP_DEQUEUE, BYTE_DATA_W'($urandom_range(255)));
        for (int i = 0; i < 3; i++)
            send_item(OP_RX_BYTE, BYTE_DATA_W'($urandom_range(255)));
        // dequeue while a record is half built must still report empty
        send_item(OP_DEQUEUE, BYTE_DATA_W'($urandom_range(255)));
        for (int i = 3; i < RECORD_BYTES; i++)
            send_item(OP_RX_BYTE, BYTE_DATA_W'($urandom_range(255)));
        send_item(OP_DEQUEUE, BYTE_DATA_W'($urandom_range(255)));

        // Random: segments that fill, drain and mix, so the queue wraps and overflows
        seg     = 0;
        seg_pos = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST) && (n <= CALM_LAST);
            if (n == HOLD_AT)
                hold_request = 1'b1;
            send_item(($urandom_range(99) < seg_pct[seg]) ? OP_DEQUEUE : OP_RX_BYTE,
                      BYTE_DATA_W'($urandom_range(255)));
            seg_pos++;
            if (seg_pos >= seg_len[seg])
            begin
                seg_pos = 0;
                seg     = (seg + 1) % 6;
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d items in, %0d results checked", items_sent, results_checked);
        $display("summary: %0d records dropped when full, %0d dequeues found the queue empty",
                 drops_seen, empties_seen);
        if (fail_count == 0 && results_owed == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/srf_pkg.sv
design/srf_ctrl.sv
design/srf_datapath.sv
design/serial_record_fifo.sv
bench/srf_checker.sv
bench/testbench.sv
